// File: rtl/ssi_pkg.sv
// Shared types and constants for the sorted set intersection block.
// No dependencies; imported by every module under rtl/.
package ssi_pkg;

  localparam int ELEM_W      = 16;
  localparam int SLOT_W      = 4;
  localparam int MAX_RESULTS = 16;
  localparam int RES_CNT_W   = $clog2(MAX_RESULTS);

  typedef enum logic [1:0] {
    REQ_WR_A    = 2'd0,
    REQ_WR_B    = 2'd1,
    REQ_COMPUTE = 2'd2
  } ssi_req_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MATCH,
    ST_FEED,
    ST_DRAIN,
    ST_EMIT
  } ssi_state_t;

  // Control for the row of store cells.
  typedef struct packed {
    logic clr;     // clear the hit flags
    logic match;   // rotate set B, compare against the held A value
    logic rotate;  // rotate set A and hit flags toward cell 0
  } ssi_store_ctl_t;

  // Control for the row of sort cells.
  typedef struct packed {
    logic clr;     // empty every cell
    logic shift;   // move the sorted list one cell toward cell 0
  } ssi_sort_ctl_t;

endpackage

// File: rtl/ssi_store_cell.sv
// One slot of both sets plus its hit flag; part of a ring of store cells.
// Depends on ssi_pkg.
module ssi_store_cell import ssi_pkg::*; #(
  parameter int VW = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  ssi_store_ctl_t ctl,
  input  logic           wr_a,
  input  logic           wr_b,
  input  logic [VW-1:0]  wr_val,
  input  logic [VW-1:0]  a_nbr,
  input  logic [VW-1:0]  b_nbr,
  input  logic           hit_nbr,
  output logic [VW-1:0]  a,
  output logic [VW-1:0]  b,
  output logic           hit
);

  always_ff @(posedge clk) begin
    if (rst) begin
      a   <= '0;
      b   <= '0;
      hit <= 1'b0;
    end else begin
      if (wr_a) begin
        a <= wr_val;
      end
      if (wr_b) begin
        b <= wr_val;
      end
      if (ctl.clr) begin
        hit <= 1'b0;
      end else if (ctl.match) begin
        // rotate B past the held A value
        b <= b_nbr;
        if ((a != '0) && (a == b)) begin
          hit <= 1'b1;
        end
      end else if (ctl.rotate) begin
        a   <= a_nbr;
        hit <= hit_nbr;
      end
    end
  end

endmodule

// File: rtl/ssi_sort_cell.sv
// One cell of a systolic insertion sorter that drops duplicate values.
// Depends on ssi_pkg.
module ssi_sort_cell import ssi_pkg::*; #(
  parameter int VW = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  ssi_sort_ctl_t ctl,
  input  logic          in_v,
  input  logic [VW-1:0] in_val,
  input  logic          nxt_vld,
  input  logic [VW-1:0] nxt_val,
  output logic          vld,
  output logic [VW-1:0] val,
  output logic          fwd_v,
  output logic [VW-1:0] fwd_val
);

  always_ff @(posedge clk) begin
    if (rst || ctl.clr) begin
      vld   <= 1'b0;
      fwd_v <= 1'b0;
    end else if (ctl.shift) begin
      vld   <= nxt_vld;
      val   <= nxt_val;
      fwd_v <= 1'b0;
    end else begin
      fwd_v <= 1'b0;
      if (in_v) begin
        if (!vld) begin
          vld <= 1'b1;
          val <= in_val;
        end else if (in_val < val) begin
          // keep the smaller, push the held value on
          val     <= in_val;
          fwd_v   <= 1'b1;
          fwd_val <= val;
        end else if (in_val != val) begin
          fwd_v   <= 1'b1;
          fwd_val <= in_val;
        end
        // equal value: drop the duplicate
      end
    end
  end

endmodule

// File: rtl/sorted_set_intersection.sv
// Sorted set intersection: two sets of SET_SIZE values, loaded slot by slot,
// and a compute request that returns their common nonzero values in order.
// Depends on ssi_pkg, ssi_store_cell and ssi_sort_cell.
//
// Load requests (write a slot of set A or set B) produce no result; a slot
// index at or above SET_SIZE and request code 3 are dropped. A compute
// request returns every distinct nonzero value held in both sets, smallest
// first, at most MAX_RESULTS of them, with last set on the final one; if
// there is none, one result with empty_res and last set and common_value
// zero. The sets live in a ring of SET_SIZE store cells. A compute runs
// three passes: set B rotates once around the ring while each cell marks a
// hit when its A value meets an equal B value; set A and the hit flags then
// rotate once through cell 0, which feeds every hit into a row of SET_SIZE
// insertion-sort cells that keep values ascending and drop duplicates; the
// row is then given a third pass to settle. Results leave from the head of
// the sorted row, one per cycle while out_stall is low, and in_stall stays
// high from the accepted compute until its last result is loaded into the
// output register. Both stores reset to empty.
module sorted_set_intersection import ssi_pkg::*; #(
  parameter int SET_SIZE    = 16,
  parameter int VALUE_WIDTH = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        req_type,
  input  logic [SLOT_W-1:0] slot,
  input  logic [ELEM_W-1:0] element_value,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [ELEM_W-1:0] common_value,
  output logic              empty_res,
  output logic              last
);

  localparam int VW = VALUE_WIDTH;
  localparam int CW = $clog2(SET_SIZE);
  localparam logic [CW-1:0] CNT_LAST = CW'(SET_SIZE - 1);

  ssi_state_t state, state_next;
  logic [CW-1:0]        cnt, cnt_next;
  logic [RES_CNT_W-1:0] ecnt;

  logic in_accept;
  logic compute_req;
  logic load;
  logic emit_last;

  ssi_store_ctl_t store_ctl;
  ssi_sort_ctl_t  sort_ctl;

  // store ring
  logic [VW-1:0] a   [SET_SIZE];
  logic [VW-1:0] b   [SET_SIZE];
  logic          hit [SET_SIZE];
  logic [VW-1:0] wr_val;
  logic [VW+ELEM_W-1:0] wr_ext;

  // sorter row; entry SET_SIZE is the empty tail seen by the last cell
  logic          svld [SET_SIZE+1];
  logic [VW-1:0] sval [SET_SIZE+1];
  logic          fwd_v   [SET_SIZE];
  logic [VW-1:0] fwd_val [SET_SIZE];
  logic          feed_v;
  logic [VW+ELEM_W-1:0] out_ext;

  assign in_accept   = in_valid && !in_stall;
  assign compute_req = in_accept && (req_type == REQ_COMPUTE);

  // mask or widen the write value to the stored width
  assign wr_ext = {{VW{1'b0}}, element_value};
  assign wr_val = wr_ext[VW-1:0];

  assign svld[SET_SIZE] = 1'b0;
  assign sval[SET_SIZE] = '0;

  // feed hits from cell 0 into the sorter while set A rotates
  assign feed_v = (state == ST_FEED) && hit[0];

  // final result: empty run, sorted list runs out, or result limit reached
  assign emit_last = !svld[0] || !svld[1] || (ecnt == RES_CNT_W'(MAX_RESULTS - 1));

  // ---------------------------------------------------------------- store ring
  for (genvar g = 0; g < SET_SIZE; g++) begin : g_store
    localparam int NX = (g + 1) % SET_SIZE;
    logic sel;
    assign sel = ({{(32-SLOT_W){1'b0}}, slot} == 32'(g));

    ssi_store_cell #(.VW(VW)) u_cell (
      .clk     (clk),
      .rst     (rst),
      .ctl     (store_ctl),
      .wr_a    (in_accept && (req_type == REQ_WR_A) && sel),
      .wr_b    (in_accept && (req_type == REQ_WR_B) && sel),
      .wr_val  (wr_val),
      .a_nbr   (a[NX]),
      .b_nbr   (b[NX]),
      .hit_nbr (hit[NX]),
      .a       (a[g]),
      .b       (b[g]),
      .hit     (hit[g])
    );
  end

  // ---------------------------------------------------------------- sorter row
  for (genvar g = 0; g < SET_SIZE; g++) begin : g_sort
    logic          cin_v;
    logic [VW-1:0] cin_val;
    if (g == 0) begin : g_head
      assign cin_v   = feed_v;
      assign cin_val = a[0];
    end else begin : g_body
      assign cin_v   = fwd_v[g-1];
      assign cin_val = fwd_val[g-1];
    end

    ssi_sort_cell #(.VW(VW)) u_cell (
      .clk     (clk),
      .rst     (rst),
      .ctl     (sort_ctl),
      .in_v    (cin_v),
      .in_val  (cin_val),
      .nxt_vld (svld[g+1]),
      .nxt_val (sval[g+1]),
      .vld     (svld[g]),
      .val     (sval[g]),
      .fwd_v   (fwd_v[g]),
      .fwd_val (fwd_val[g])
    );
  end

  // ---------------------------------------------------------------- sequencer
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    case (state)
      ST_IDLE: begin
        cnt_next = '0;
        if (compute_req) begin
          state_next = ST_MATCH;
        end
      end
      ST_MATCH, ST_FEED, ST_DRAIN: begin
        if (cnt == CNT_LAST) begin
          cnt_next = '0;
          case (state)
            ST_MATCH: state_next = ST_FEED;
            ST_FEED:  state_next = ST_DRAIN;
            default:  state_next = ST_EMIT;
          endcase
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      ST_EMIT: begin
        if (load && emit_last) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall         = (state != ST_IDLE);
    store_ctl.clr    = compute_req;
    store_ctl.match  = (state == ST_MATCH);
    store_ctl.rotate = (state == ST_FEED);
    load             = (state == ST_EMIT) && (!out_valid || !out_stall);
    sort_ctl.clr     = compute_req;
    sort_ctl.shift   = load && svld[0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
      ecnt  <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      if (compute_req) begin
        ecnt <= '0;
      end else if (load) begin
        ecnt <= ecnt + 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------- output register
  // Hold the result while stalled; load the next one when the register frees up.
  assign out_ext = {{ELEM_W{1'b0}}, sval[0]};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      common_value <= svld[0] ? out_ext[ELEM_W-1:0] : '0;
      empty_res    <= !svld[0];
      last         <= emit_last;
    end
  end

endmodule

// File: verif/sorted_set_intersection_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for sorted_set_intersection: directed and random set loads and
// compute requests, each result checked against a predictor kept inside this bench.
// Depends on ssi_pkg and the sorted_set_intersection RTL; needs no files or arguments.
module sorted_set_intersection_test;
  import ssi_pkg::*;

  localparam int SET_SIZE      = 16;
  localparam int VALUE_WIDTH   = 16;
  localparam int MAX_IDLE      = 18;    // longest gap drawn by either side, in cycles
  localparam int LONG_HOLD     = 300;   // receiver hold-off used to fill the block
  localparam int QUIET_LIMIT   = 4000;  // cycles with no handshake before giving up
  localparam int RANDOM_ITEMS  = 75;
  // A compute needs three passes over the sets plus the emission of its results.
  localparam int SETTLE_CYCLES = 3 * SET_SIZE + MAX_RESULTS + 8;
  localparam logic [1:0] REQ_UNUSED = 2'd3;  // request code the block must drop
  localparam logic [ELEM_W-1:0] VALUE_MASK = {ELEM_W{1'b1}} >> (ELEM_W - VALUE_WIDTH);

  // Value mixes for the random rounds.
  typedef enum int {
    MIX_SMALL,   // tiny value pool: many duplicates and matches
    MIX_WIDE,    // full 16-bit values, often copied across sets
    MIX_SPARSE,  // small values with many empty slots
    MIX_FULL     // both sets full of the same distinct values
  } mix_t;

  typedef struct packed {
    logic [ELEM_W-1:0] value;
    logic              empty_flag;
    logic              last_flag;
  } common_result_t;

  logic              clk;
  logic              rst;
  logic              in_valid;
  logic              in_stall;
  logic [1:0]        req_type;
  logic [SLOT_W-1:0] slot;
  logic [ELEM_W-1:0] element_value;
  logic              out_valid;
  logic              out_stall;
  logic [ELEM_W-1:0] common_value;
  logic              empty_res;
  logic              last;

  // Predictor state: shadow copies of both stores.
  logic [ELEM_W-1:0] set_a [SET_SIZE];
  logic [ELEM_W-1:0] set_b [SET_SIZE];
  common_result_t    expected_common [$];

  int mismatch_count = 0;
  int items_sent     = 0;
  bit tx_idle        = 1'b0;  // sender draws gaps between requests
  bit rx_idle        = 1'b0;  // receiver draws stalls between results
  bit long_hold_req  = 1'b0;  // ask the receiver for one long hold-off

  sorted_set_intersection #(
    .SET_SIZE    (SET_SIZE),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .req_type      (req_type),
    .slot          (slot),
    .element_value (element_value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .common_value  (common_value),
    .empty_res     (empty_res),
    .last          (last)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  //--------------------------------------------------------------------------
  // Predictor
  //--------------------------------------------------------------------------

  function automatic bit held_in_b(logic [ELEM_W-1:0] v);
    for (int j = 0; j < SET_SIZE; j++) begin
      if (set_b[j] == v) return 1'b1;
    end
    return 1'b0;
  endfunction

  // Apply one accepted request to the shadow stores; for a compute, queue
  // the common values it must return, smallest first.
  function automatic void predict_request(logic [1:0] rq, logic [SLOT_W-1:0] sl,
                                          logic [ELEM_W-1:0] ev);
    logic [ELEM_W-1:0] common [SET_SIZE];
    int                n;
    int                pos;
    common_result_t    r;
    n = 0;
    case (rq)
      REQ_WR_A: begin
        if (int'(sl) < SET_SIZE) set_a[sl] = ev & VALUE_MASK;
      end
      REQ_WR_B: begin
        if (int'(sl) < SET_SIZE) set_b[sl] = ev & VALUE_MASK;
      end
      REQ_COMPUTE: begin
        // Insertion sort of the hits; drop a value already in the list.
        for (int i = 0; i < SET_SIZE; i++) begin
          if (set_a[i] != '0 && held_in_b(set_a[i])) begin
            pos = 0;
            while (pos < n && common[pos] < set_a[i]) pos++;
            if (pos == n || common[pos] != set_a[i]) begin
              for (int k = n; k > pos; k--) common[k] = common[k-1];
              common[pos] = set_a[i];
              n++;
            end
          end
        end
        if (n > MAX_RESULTS) n = MAX_RESULTS;
        if (n == 0) begin
          r.value      = '0;
          r.empty_flag = 1'b1;
          r.last_flag  = 1'b1;
          expected_common.push_back(r);
        end else begin
          for (int k = 0; k < n; k++) begin
            r.value      = common[k];
            r.empty_flag = 1'b0;
            r.last_flag  = (k == n - 1);
            expected_common.push_back(r);
          end
        end
      end
      default: ;  // unused code: nothing happens
    endcase
  endfunction

  //--------------------------------------------------------------------------
  // Request side
  //--------------------------------------------------------------------------

  // Offer one request after a drawn gap; hold it until the block takes it,
  // then update the predictor.
  task automatic send_request(input logic [1:0] rq, input logic [SLOT_W-1:0] sl,
                              input logic [ELEM_W-1:0] ev);
    int gap;
    gap = tx_idle ? $urandom_range(0, MAX_IDLE) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    req_type      <= rq;
    slot          <= sl;
    element_value <= ev;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_request(rq, sl, ev);
    items_sent++;
  endtask

  // Hold the request side idle until every queued result has come back.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_common.size() != 0) @(posedge clk);
  endtask

  function automatic logic [ELEM_W-1:0] pick_value(mix_t mix, bit to_b);
    case (mix)
      MIX_SMALL: return ELEM_W'($urandom_range(1, 12));
      MIX_WIDE: begin
        // Copy a value from the other set half the time so matches occur.
        if ($urandom_range(0, 1) == 0) begin
          return to_b ? set_a[$urandom_range(0, SET_SIZE - 1)]
                      : set_b[$urandom_range(0, SET_SIZE - 1)];
        end
        return ELEM_W'($urandom);
      end
      default: begin
        if ($urandom_range(0, 2) == 0) return '0;
        return ELEM_W'($urandom_range(1, 40));
      end
    endcase
  endfunction

  //--------------------------------------------------------------------------
  // Tests
  //--------------------------------------------------------------------------

  // Both stores are empty after reset: expect the single empty result, and
  // an unused request code must not touch anything.
  task automatic test_empty_stores();
    send_request(REQ_COMPUTE, '0, '0);
    send_request(REQ_UNUSED, SLOT_W'(SET_SIZE - 1), '1);
    send_request(REQ_COMPUTE, '1, '1);
  endtask

  // Extreme values and slots, duplicates in each set, an unmatched value,
  // an ignored request, and zero writes that empty slots again.
  task automatic test_extremes_and_duplicates();
    send_request(REQ_WR_A, '0, '1);
    send_request(REQ_WR_B, '1, '1);
    send_request(REQ_WR_A, '1, ELEM_W'(1));
    send_request(REQ_WR_B, '0, ELEM_W'(1));
    send_request(REQ_WR_A, SLOT_W'(7), ELEM_W'(1));     // duplicate in set A
    send_request(REQ_WR_B, SLOT_W'(8), ELEM_W'(1));     // duplicate in set B
    send_request(REQ_WR_A, SLOT_W'(3), ELEM_W'(16'h8000));  // no partner in B
    send_request(REQ_COMPUTE, '0, '0);
    send_request(REQ_UNUSED, SLOT_W'(3), ELEM_W'(16'h8000));  // would match if taken as B
    send_request(REQ_COMPUTE, '0, '0);
    send_request(REQ_WR_A, '0, '0);
    send_request(REQ_WR_A, '1, '0);
    send_request(REQ_WR_A, SLOT_W'(7), '0);
    send_request(REQ_COMPUTE, '0, '0);
    wait_drained();
  endtask

  // Rounds of loads with random content, each closed by a compute; a few
  // noise requests mixed in, and full sets now and then for the most results.
  task automatic test_random_sets();
    int   first_item;
    int   rounds;
    int   writes;
    int   base;
    int   step;
    int   shift;
    bit   to_b;
    mix_t mix;
    first_item = items_sent;
    rounds     = 0;
    while (items_sent - first_item < RANDOM_ITEMS) begin
      if (rounds == 1 || $urandom_range(0, 9) == 0) mix = MIX_FULL;
      else mix = mix_t'($urandom_range(0, 2));
      // Leave some rounds with no idling on one side or both.
      tx_idle = ($urandom_range(0, 3) != 0);
      rx_idle = ($urandom_range(0, 3) != 0);
      if (mix == MIX_FULL) begin
        base  = $urandom_range(1, 60000);
        step  = $urandom_range(1, 300);
        shift = $urandom_range(0, SET_SIZE - 1);
        for (int i = 0; i < SET_SIZE; i++) begin
          send_request(REQ_WR_A, SLOT_W'(i), ELEM_W'(base + i * step));
          send_request(REQ_WR_B, SLOT_W'((i + shift) % SET_SIZE), ELEM_W'(base + i * step));
        end
      end else begin
        writes = $urandom_range(2, 14);
        repeat (writes) begin
          if ($urandom_range(0, 9) == 0) begin
            send_request(REQ_UNUSED, SLOT_W'($urandom), ELEM_W'($urandom));
          end else begin
            to_b = $urandom_range(0, 1);
            send_request(to_b ? REQ_WR_B : REQ_WR_A, SLOT_W'($urandom_range(0, SET_SIZE - 1)),
                         pick_value(mix, to_b));
          end
        end
      end
      // Slot and value are don't-care on a compute: randomize them.
      send_request(REQ_COMPUTE, SLOT_W'($urandom), ELEM_W'($urandom));
      if ($urandom_range(0, 5) == 0) send_request(REQ_COMPUTE, SLOT_W'($urandom), '0);
      rounds++;
    end
    wait_drained();
  endtask

  // Hold off the receiver for a long stretch while requests keep coming so
  // the block fills and stalls its input, then pause until all results land.
  task automatic test_full_backpressure();
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    for (int i = 0; i < 6; i++) begin
      send_request(REQ_WR_A, SLOT_W'(i), ELEM_W'((i + 1) * 7));
      send_request(REQ_WR_B, SLOT_W'(SET_SIZE - 1 - i), ELEM_W'((i + 1) * 7));
    end
    long_hold_req = 1'b1;
    send_request(REQ_COMPUTE, '0, '0);
    send_request(REQ_WR_A, SLOT_W'(6), ELEM_W'(99));
    send_request(REQ_WR_B, SLOT_W'(9), ELEM_W'(99));
    send_request(REQ_COMPUTE, '0, '0);
    send_request(REQ_WR_B, SLOT_W'(SET_SIZE - 1), '0);
    send_request(REQ_COMPUTE, '0, '0);
    wait_drained();
  endtask

  //--------------------------------------------------------------------------
  // Result side
  //--------------------------------------------------------------------------

  // Draw a stall before each result; a long hold request overrides it.
  initial begin : result_receiver
    int wait_left;
    int hold_left;
    wait_left = 0;
    hold_left = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left     = LONG_HOLD;
      end
      if (out_valid && !out_stall) wait_left = rx_idle ? $urandom_range(0, MAX_IDLE) : 0;
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (wait_left > 0) begin
        wait_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic note_mismatch(input string msg);
    if (mismatch_count < 10) $display("mismatch at %0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // Compare every accepted result with the oldest pending expectation.
  always @(posedge clk) begin : check_common
    common_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_common.size() == 0) begin
        note_mismatch($sformatf("unexpected result value %h empty %b last %b",
                                common_value, empty_res, last));
      end else begin
        want = expected_common.pop_front();
        if (common_value !== want.value || empty_res !== want.empty_flag ||
            last !== want.last_flag) begin
          note_mismatch($sformatf("want value %h empty %b last %b, got value %h empty %b last %b",
                                  want.value, want.empty_flag, want.last_flag,
                                  common_value, empty_res, last));
        end
      end
    end
  end

  // Give up when no handshake happens on either side for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("timeout: no handshake for %0d cycles", QUIET_LIMIT);
    $display("CHECK FAILED");
    $finish;
  end

  //--------------------------------------------------------------------------
  // Sequence
  //--------------------------------------------------------------------------

  initial begin : run_tests
    for (int i = 0; i < SET_SIZE; i++) begin
      set_a[i] = '0;
      set_b[i] = '0;
    end
    rst           <= 1'b1;
    in_valid      <= 1'b0;
    req_type      <= REQ_WR_A;
    slot          <= '0;
    element_value <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    test_empty_stores();
    test_extremes_and_duplicates();
    test_random_sets();
    test_full_backpressure();

    // Drain, then watch a while longer for stray results.
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_common.size() != 0) note_mismatch("results still expected at end of run");
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
